/* rtl/tpg_pkg.sv */
package tpg_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned N_COORD   = 9;

  // centroid: offset sum then multiply by a reciprocal of three
  localparam int unsigned CS_W      = COORD_W + 2;
  localparam int unsigned RECIP_W   = 36;
  localparam int unsigned DIV3_SH   = 37;
  localparam logic [RECIP_W-1:0] DIV3_MUL = 36'hAAAAAAAAB;
  localparam int unsigned CP_W      = CS_W + RECIP_W;
  localparam logic signed [CS_W:0] CEN_OFS = 35'sd6442450945;

  // cross product and normalisation
  localparam int unsigned EDGE_W    = COORD_W + 1;
  localparam int unsigned PROD_W    = 2 * EDGE_W;
  localparam int unsigned CROSS_W   = PROD_W + 1;
  localparam int unsigned MAG_W     = PROD_W;
  localparam int unsigned A_W       = MAG_W - 3;
  localparam int unsigned AHI_W     = A_W - 32;
  localparam int unsigned ASQ_W     = 2 * A_W;
  localparam int unsigned LSQ_W     = ASQ_W + 2;
  localparam int unsigned L_W       = LSQ_W / 2;
  localparam int unsigned SH_W      = 7;
  localparam int unsigned Q_W       = 32;
  localparam logic [Q_W-1:0] NORM_ONE = 32'h4000_0000;

  // radius
  localparam int unsigned DM_W      = EDGE_W;
  localparam int unsigned RSQ_W     = 2 * DM_W;
  localparam int unsigned RROOT_W   = RSQ_W / 2;
  localparam int unsigned RREM_W    = RROOT_W + 3;
  localparam int unsigned RAD_W     = 33;

  // area
  localparam int unsigned AREA_W    = 48;
  localparam int unsigned AREA_SH_BASE = 2 * FRAC_BITS - 19;
  localparam logic [AREA_W-1:0] AREA_MAX = '1;

  typedef struct packed {
    logic [2:0] neg;
    logic       flip;
    logic       nz;
  } tpg_side_t;

  localparam int unsigned SIDE_W = $bits(tpg_side_t);

endpackage

/* rtl/triangle_panel_geometry.sv */
// Throughput: one triangle per cycle; the 64-step pipelined square root of the
// normal length and the 32-step pipelined divider set the depth.
// A stall on the output freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst_ni low, asynchronous) clears the valid bits only.
module triangle_panel_geometry (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z (32 bits each)
  input  logic [287:0] s_axis_tdata,
  // flip_normal
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // centroid_x, centroid_y, centroid_z (32), bound_radius (33),
  // normal_x, normal_y, normal_z (32), area (48), 7 zero bits
  output logic [279:0] m_axis_tdata
);
  import tpg_pkg::*;

  localparam int unsigned LAT       = 107;
  localparam int unsigned CEN_DLY   = 103;
  localparam int unsigned RAD_DLY   = 66;
  localparam int unsigned A_DLY     = 66;
  localparam int unsigned AREA_DLY  = 31;
  localparam int unsigned D1_W      = 3 * A_W + SH_W + SIDE_W;
  localparam int unsigned D2_W      = AREA_W + SIDE_W;
  localparam logic signed [Q_W-1:0] NRM_POS = 32'sh4000_0000;
  localparam logic signed [Q_W-1:0] NRM_NEG = -32'sh4000_0000;

  logic           en;
  logic [LAT-1:0] vld_q;

  assign en            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // ---------------- stage 1: offset sums and edges
  logic signed [COORD_W-1:0] vin     [N_COORD];
  logic signed [CS_W:0]      csum    [3];
  logic signed [COORD_W-1:0] v1_q    [N_COORD];
  logic [CS_W-1:0]           u1_q    [3];
  logic signed [EDGE_W-1:0]  ea1_q   [3];
  logic signed [EDGE_W-1:0]  eb1_q   [3];
  logic                      flip1_q;

  always_comb begin
    for (int k = 0; k < N_COORD; k++) begin
      vin[k] = s_axis_tdata[COORD_W*k +: COORD_W];
    end
    for (int j = 0; j < 3; j++) begin
      csum[j] = (CS_W + 1)'(vin[j]) + (CS_W + 1)'(vin[3+j]) + (CS_W + 1)'(vin[6+j]) + CEN_OFS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < N_COORD; k++) v1_q[k] <= vin[k];
      for (int j = 0; j < 3; j++) begin
        u1_q[j]  <= csum[j][CS_W-1:0];
        ea1_q[j] <= EDGE_W'(vin[3+j]) - EDGE_W'(vin[j]);
        eb1_q[j] <= EDGE_W'(vin[6+j]) - EDGE_W'(vin[j]);
      end
      flip1_q <= s_axis_tuser[0];
    end
  end

  // ---------------- stage 2: reciprocal and cross-product multiplies
  logic [CP_W-1:0]           cp2_q [3];
  logic signed [PROD_W-1:0]  xp2_q [6];
  logic signed [COORD_W-1:0] v2_q  [N_COORD];
  logic                      flip2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) cp2_q[j] <= u1_q[j] * DIV3_MUL;
      xp2_q[0] <= ea1_q[1] * eb1_q[2];
      xp2_q[1] <= ea1_q[2] * eb1_q[1];
      xp2_q[2] <= ea1_q[2] * eb1_q[0];
      xp2_q[3] <= ea1_q[0] * eb1_q[2];
      xp2_q[4] <= ea1_q[0] * eb1_q[1];
      xp2_q[5] <= ea1_q[1] * eb1_q[0];
      v2_q     <= v1_q;
      flip2_q  <= flip1_q;
    end
  end

  // ---------------- stage 3: centroid and normal vector
  logic signed [COORD_W-1:0] cen3_q [3];
  logic signed [CROSS_W-1:0] n3_q   [3];
  logic signed [COORD_W-1:0] v3_q   [N_COORD];
  logic                      flip3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        // quotient lies in [0, 2^32): remove the offset by flipping the top bit
        cen3_q[j] <= {~cp2_q[j][DIV3_SH+COORD_W-1], cp2_q[j][DIV3_SH+COORD_W-2:DIV3_SH]};
        n3_q[j]   <= CROSS_W'(xp2_q[2*j]) - CROSS_W'(xp2_q[2*j+1]);
      end
      v3_q    <= v2_q;
      flip3_q <= flip2_q;
    end
  end

  // ---------------- stage 4: magnitudes
  logic signed [EDGE_W-1:0]  dd   [N_COORD];
  logic signed [CROSS_W-1:0] nneg [3];
  logic [DM_W-1:0]           dm4_q   [N_COORD];
  logic [MAG_W-1:0]          mag4_q  [3];
  logic [2:0]                neg4_q;
  logic                      flip4_q;

  always_comb begin
    for (int k = 0; k < N_COORD; k++) begin
      dd[k] = EDGE_W'(v3_q[k]) - EDGE_W'(cen3_q[k % 3]);
    end
    for (int j = 0; j < 3; j++) nneg[j] = -n3_q[j];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < N_COORD; k++) begin
        dm4_q[k] <= dd[k][EDGE_W-1] ? DM_W'(-dd[k]) : DM_W'(dd[k]);
      end
      for (int j = 0; j < 3; j++) begin
        neg4_q[j] <= n3_q[j][CROSS_W-1];
        mag4_q[j] <= n3_q[j][CROSS_W-1] ? nneg[j][MAG_W-1:0] : n3_q[j][MAG_W-1:0];
      end
      flip4_q <= flip3_q;
    end
  end

  // ---------------- stage 5: squared distances, largest normal component
  logic [RSQ_W-1:0] sq5_q  [N_COORD];
  logic [MAG_W-1:0] mx5_q;
  logic [MAG_W-1:0] mag5_q [3];
  logic [2:0]       neg5_q;
  logic             flip5_q;
  logic [MAG_W-1:0] mx_d;

  always_comb begin
    mx_d = mag4_q[0];
    if (mag4_q[1] > mx_d) mx_d = mag4_q[1];
    if (mag4_q[2] > mx_d) mx_d = mag4_q[2];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < N_COORD; k++) sq5_q[k] <= dm4_q[k] * dm4_q[k];
      mx5_q   <= mx_d;
      mag5_q  <= mag4_q;
      neg5_q  <= neg4_q;
      flip5_q <= flip4_q;
    end
  end

  // ---------------- stage 6: distance sums, coarse normalisation
  logic [RSQ_W-1:0] rs6_q [3];
  logic [MAG_W-1:0] m6_q;
  logic [MAG_W-1:0] mag6_q [3];
  logic [SH_W-1:0]  sh6_q;
  tpg_side_t        side6_q;
  logic [MAG_W-1:0] ma_d, mb_d;
  logic [MAG_W-1:0] mga_d [3];
  logic [MAG_W-1:0] mgb_d [3];
  logic [SH_W-1:0]  sa_d, sb_d;

  always_comb begin
    ma_d  = mx5_q;
    mga_d = mag5_q;
    sa_d  = '0;
    if (ma_d[MAG_W-1:2] == '0) begin
      ma_d = ma_d << 64;
      for (int j = 0; j < 3; j++) mga_d[j] = mga_d[j] << 64;
      sa_d = sa_d | 7'd64;
    end
    if (ma_d[MAG_W-1:MAG_W-32] == '0) begin
      ma_d = ma_d << 32;
      for (int j = 0; j < 3; j++) mga_d[j] = mga_d[j] << 32;
      sa_d = sa_d | 7'd32;
    end
    if (ma_d[MAG_W-1:MAG_W-16] == '0) begin
      ma_d = ma_d << 16;
      for (int j = 0; j < 3; j++) mga_d[j] = mga_d[j] << 16;
      sa_d = sa_d | 7'd16;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        rs6_q[j] <= sq5_q[3*j] + sq5_q[3*j+1] + sq5_q[3*j+2];
      end
      m6_q         <= ma_d;
      mag6_q       <= mga_d;
      sh6_q        <= sa_d;
      side6_q.neg  <= neg5_q;
      side6_q.flip <= flip5_q;
      side6_q.nz   <= (mx5_q != '0);
    end
  end

  // ---------------- stage 7: fine normalisation
  logic [MAG_W-1:0] mag7_q [3];
  logic [SH_W-1:0]  sh7_q;
  tpg_side_t        side7_q;

  always_comb begin
    mb_d  = m6_q;
    mgb_d = mag6_q;
    sb_d  = sh6_q;
    if (mb_d[MAG_W-1:MAG_W-8] == '0) begin
      mb_d = mb_d << 8;
      for (int j = 0; j < 3; j++) mgb_d[j] = mgb_d[j] << 8;
      sb_d = sb_d | 7'd8;
    end
    if (mb_d[MAG_W-1:MAG_W-4] == '0) begin
      mb_d = mb_d << 4;
      for (int j = 0; j < 3; j++) mgb_d[j] = mgb_d[j] << 4;
      sb_d = sb_d | 7'd4;
    end
    if (mb_d[MAG_W-1:MAG_W-2] == '0) begin
      mb_d = mb_d << 2;
      for (int j = 0; j < 3; j++) mgb_d[j] = mgb_d[j] << 2;
      sb_d = sb_d | 7'd2;
    end
    if (!mb_d[MAG_W-1]) begin
      for (int j = 0; j < 3; j++) mgb_d[j] = mgb_d[j] << 1;
      sb_d = sb_d | 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag7_q  <= mgb_d;
      sh7_q   <= sb_d;
      side7_q <= side6_q;
    end
  end

  // ---------------- stage 8: partial products of the squares
  logic [A_W-1:0]        a8_q  [3];
  logic [2*AHI_W-1:0]    hh8_q [3];
  logic [AHI_W+31:0]     hl8_q [3];
  logic [63:0]           ll8_q [3];
  logic [SH_W-1:0]       sh8_q;
  tpg_side_t             side8_q;
  logic [A_W-1:0]        a7    [3];

  always_comb begin
    for (int j = 0; j < 3; j++) a7[j] = mag7_q[j][MAG_W-1:3];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        a8_q[j]  <= a7[j];
        hh8_q[j] <= a7[j][A_W-1:32] * a7[j][A_W-1:32];
        hl8_q[j] <= a7[j][A_W-1:32] * a7[j][31:0];
        ll8_q[j] <= a7[j][31:0] * a7[j][31:0];
      end
      sh8_q   <= sh7_q;
      side8_q <= side7_q;
    end
  end

  // ---------------- stages 9 and 10: sum of squares
  logic [ASQ_W-1:0] sqa9_q [3];
  logic [LSQ_W-1:0] sum10_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        sqa9_q[j] <= (ASQ_W'(hh8_q[j]) << 64) + (ASQ_W'(hl8_q[j]) << 33) + ASQ_W'(ll8_q[j]);
      end
      sum10_q <= LSQ_W'(sqa9_q[0]) + LSQ_W'(sqa9_q[1]) + LSQ_W'(sqa9_q[2]);
    end
  end

  // ---------------- normal length, stages 11 to 74
  logic [L_W-1:0] len_root;

  tpg_isqrt #(.W(LSQ_W)) u_len_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (sum10_q),
    .root_o (len_root),
    .rem_o  ()
  );

  logic [D1_W-1:0] d1_in, d1_out;
  logic [A_W-1:0]  a74 [3];
  logic [SH_W-1:0] sh74;
  tpg_side_t       side74;

  assign d1_in = {a8_q[2], a8_q[1], a8_q[0], sh8_q, side8_q};

  tpg_delay #(.W(D1_W), .DEPTH(A_DLY)) u_a_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (d1_in),
    .q_o   (d1_out)
  );

  assign {a74[2], a74[1], a74[0], sh74, side74} = d1_out;

  // ---------------- stage 75: area
  logic [7:0]       ash;
  logic [L_W-1:0]   apre;
  logic [L_W:0]     arnd;
  logic [AREA_W-1:0] area75_q;
  tpg_side_t        side75_q;

  always_comb begin
    ash  = 8'(AREA_SH_BASE) + 8'(sh74);
    apre = (ash >= 8'd64) ? '0 : (len_root >> ash[5:0]);
    arnd = ((L_W + 1)'(apre) + 1'b1) >> 1;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      area75_q <= (arnd > (L_W + 1)'(AREA_MAX)) ? AREA_MAX : arnd[AREA_W-1:0];
      side75_q <= side74;
    end
  end

  logic [D2_W-1:0]   d2_out;
  logic [AREA_W-1:0] area106;
  tpg_side_t         side106;

  tpg_delay #(.W(D2_W), .DEPTH(AREA_DLY)) u_area_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({area75_q, side75_q}),
    .q_o   (d2_out)
  );

  assign {area106, side106} = d2_out;

  // ---------------- component / length, stages 75 to 106
  logic [Q_W-1:0] quo [3];

  for (genvar j = 0; j < 3; j++) begin : g_div
    tpg_div #(.NW(A_W), .DW(L_W), .QW(Q_W)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (a74[j]),
      .den_i (len_root),
      .quo_o (quo[j])
    );
  end

  // ---------------- radius, stages 7 to 40
  logic [RROOT_W-1:0] rroot [3];
  logic [RREM_W-1:0]  rrem  [3];

  for (genvar j = 0; j < 3; j++) begin : g_rad
    tpg_isqrt #(.W(RSQ_W)) u_rad_sqrt (
      .clk_i  (clk_i),
      .en_i   (en),
      .x_i    (rs6_q[j]),
      .root_o (rroot[j]),
      .rem_o  (rrem[j])
    );
  end

  logic [RROOT_W:0] rrnd [3];
  logic [RROOT_W:0] rmax;
  logic [RAD_W-1:0] rad40_q;
  logic [RAD_W-1:0] rad106;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rrnd[j] = (rrem[j] > RREM_W'(rroot[j])) ? (RROOT_W + 1)'(rroot[j]) + 1'b1
                                               : (RROOT_W + 1)'(rroot[j]);
    end
    rmax = rrnd[0];
    if (rrnd[1] > rmax) rmax = rrnd[1];
    if (rrnd[2] > rmax) rmax = rrnd[2];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad40_q <= rmax[RROOT_W] ? '1 : rmax[RAD_W-1:0];
    end
  end

  tpg_delay #(.W(RAD_W), .DEPTH(RAD_DLY)) u_rad_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (rad40_q),
    .q_o   (rad106)
  );

  logic [3*COORD_W-1:0] cen106;

  tpg_delay #(.W(3 * COORD_W), .DEPTH(CEN_DLY)) u_cen_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({cen3_q[2], cen3_q[1], cen3_q[0]}),
    .q_o   (cen106)
  );

  // ---------------- stage 107: round, clamp, sign; output register
  logic [Q_W:0]      qr   [3];
  logic [Q_W-1:0]    qh   [3];
  logic [Q_W-1:0]    nrm_d [3];
  logic [3*COORD_W-1:0] out_cen_q;
  logic [RAD_W-1:0]  out_rad_q;
  logic [Q_W-1:0]    out_nrm_q [3];
  logic [AREA_W-1:0] out_area_q;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      qr[j] = ((Q_W + 1)'(quo[j]) + 1'b1) >> 1;
      qh[j] = (qr[j] > (Q_W + 1)'(NORM_ONE)) ? NORM_ONE : qr[j][Q_W-1:0];
      if (!side106.nz) begin
        nrm_d[j] = '0;
      end else if (side106.neg[j] ^ side106.flip) begin
        nrm_d[j] = -qh[j];
      end else begin
        nrm_d[j] = qh[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_cen_q  <= cen106;
      out_rad_q  <= rad106;
      out_nrm_q  <= nrm_d;
      out_area_q <= side106.nz ? area106 : '0;
    end
  end

  assign m_axis_tdata = {7'd0, out_area_q, out_nrm_q[2], out_nrm_q[1], out_nrm_q[0],
                         out_rad_q, out_cen_q};

  // ---------------- checks
  a_nrm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ($signed(out_nrm_q[0]) <= NRM_POS) && ($signed(out_nrm_q[0]) >= NRM_NEG) &&
      ($signed(out_nrm_q[1]) <= NRM_POS) && ($signed(out_nrm_q[1]) >= NRM_NEG) &&
      ($signed(out_nrm_q[2]) <= NRM_POS) && ($signed(out_nrm_q[2]) >= NRM_NEG))
    else $error("normal component beyond unit range");

  a_flat_no_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_nrm_q[0] == '0 && out_nrm_q[1] == '0 && out_nrm_q[2] == '0)
      |-> (out_area_q == '0))
    else $error("zero normal with nonzero area");

  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(vld_q[LAT-2]))
    else $error("output beat without a beat in the last stage");

endmodule

/* rtl/tpg_delay.sv */
module tpg_delay #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] pipe_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        pipe_q[k] <= pipe_q[k-1];
      end
    end
  end

  assign q_o = pipe_q[DEPTH-1];

endmodule

/* rtl/tpg_isqrt.sv */
module tpg_isqrt #(
  parameter int unsigned W = 66
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [W-1:0]     x_i,
  output logic [W/2-1:0]   root_o,
  output logic [W/2+2:0]   rem_o
);

  localparam int unsigned N  = W / 2;
  localparam int unsigned RW = N + 3;

  logic [W-1:0]  x_q    [N-1];
  logic [N-1:0]  root_q [N];
  logic [RW-1:0] rem_q  [N];

  // one result bit per stage, two radicand bits shifted in
  for (genvar j = 0; j < N; j++) begin : g_stage
    logic [W-1:0]  x_cur;
    logic [N-1:0]  root_cur;
    logic [RW-1:0] rem_cur;
    logic [RW-1:0] acc;
    logic [RW-1:0] trial;

    if (j == 0) begin : g_first
      assign x_cur    = x_i;
      assign root_cur = '0;
      assign rem_cur  = '0;
    end else begin : g_next
      assign x_cur    = x_q[j-1];
      assign root_cur = root_q[j-1];
      assign rem_cur  = rem_q[j-1];
    end

    assign acc   = {rem_cur[RW-3:0], x_cur[W-1:W-2]};
    assign trial = {1'b0, root_cur, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (acc >= trial) begin
          rem_q[j]  <= acc - trial;
          root_q[j] <= {root_cur[N-2:0], 1'b1};
        end else begin
          rem_q[j]  <= acc;
          root_q[j] <= {root_cur[N-2:0], 1'b0};
        end
      end
    end

    if (j < N - 1) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[j] <= x_cur << 2;
        end
      end
    end
  end

  assign root_o = root_q[N-1];
  assign rem_o  = rem_q[N-1];

endmodule

/* rtl/tpg_div.sv */
module tpg_div #(
  parameter int unsigned NW = 63,
  parameter int unsigned DW = 64,
  parameter int unsigned QW = 32
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_q [QW-1];
  logic [DW-1:0] den_q [QW-1];
  logic [QW-1:0] quo_q [QW];

  // restoring division, one quotient bit per stage; numerator below twice the divisor
  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [DW:0]   rin;
    logic [DW-1:0] den_cur;
    logic [DW:0]   diff;
    logic          ge;

    if (j == 0) begin : g_first
      assign rin     = (DW + 1)'(num_i);
      assign den_cur = den_i;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          quo_q[j] <= QW'(ge);
        end
      end
    end else begin : g_next
      assign rin     = {rem_q[j-1], 1'b0};
      assign den_cur = den_q[j-1];

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          quo_q[j] <= {quo_q[j-1][QW-2:0], ge};
        end
      end
    end

    assign diff = rin - {1'b0, den_cur};
    assign ge   = (rin >= {1'b0, den_cur});

    if (j < QW - 1) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= ge ? diff[DW-1:0] : rin[DW-1:0];
          den_q[j] <= den_cur;
        end
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import tpg_pkg::*;

  localparam int unsigned IN_W        = 288;
  localparam int unsigned OUT_W       = 280;
  localparam int unsigned LATENCY     = 107;
  localparam int unsigned WD_LIMIT    = 4000;
  localparam int          HOLD_CYCLES = 400;

  typedef struct packed {
    logic        flip;
    logic [8:0][31:0] crd;
  } triangle_t;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;
  logic [0:0]       s_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;

  logic [OUT_W-1:0] geom_expected_q[$];
  int               errors = 0;
  int               idle_pct;
  int               stall_pct;
  int               hold_seq = 0;
  int               hold_seen = 0;
  int               hold_cnt;
  int               quiet_cycles = 0;

  triangle_panel_geometry dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [63:0] isqrt128(logic [127:0] s);
    logic [63:0]  r;
    logic [63:0]  c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= s) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] mean_of_three(logic signed [63:0] a,
                                                       logic signed [63:0] b,
                                                       logic signed [63:0] c);
    logic [63:0]        u;
    logic signed [63:0] q;
    u = a + b + c + (64'd3 << 31);
    q = $signed(u / 3) - (64'sd1 <<< 31);
    if (u % 3 == 2) q = q + 1;
    return q;
  endfunction

  function automatic logic [OUT_W-1:0] predict_geometry(triangle_t t);
    logic signed [63:0]  v[3][3];
    logic signed [63:0]  cen[3];
    logic signed [127:0] ea[3], eb[3], nrm[3];
    logic [127:0]        mag[3], mx, sq, d, rem, num;
    logic [63:0]         a[3], lroot, rad, r, area, q;
    logic                neg[3];
    logic signed [31:0]  nq[3];
    int                  bl, up, down, sh;
    logic [OUT_W-1:0]    res;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) v[i][j] = $signed(t.crd[i*3+j]);
    for (int j = 0; j < 3; j++) cen[j] = mean_of_three(v[0][j], v[1][j], v[2][j]);
    rad = '0;
    for (int i = 0; i < 3; i++) begin
      sq = '0;
      for (int j = 0; j < 3; j++) begin
        d = 128'(v[i][j] - cen[j]);
        if (d[127]) d = -d;
        sq = sq + d * d;
      end
      r = isqrt128(sq);
      rem = sq - {64'd0, r} * {64'd0, r};
      if (rem > {64'd0, r}) r = r + 1;
      if (r > rad) rad = r;
    end
    if (rad > 64'h1_FFFF_FFFF) rad = 64'h1_FFFF_FFFF;
    for (int j = 0; j < 3; j++) begin
      ea[j] = v[1][j] - v[0][j];
      eb[j] = v[2][j] - v[0][j];
    end
    nrm[0] = ea[1] * eb[2] - ea[2] * eb[1];
    nrm[1] = ea[2] * eb[0] - ea[0] * eb[2];
    nrm[2] = ea[0] * eb[1] - ea[1] * eb[0];
    mx = '0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = nrm[i][127];
      mag[i] = neg[i] ? -nrm[i] : nrm[i];
      if (mag[i] > mx) mx = mag[i];
      nq[i] = '0;
    end
    area = '0;
    if (mx != 0) begin
      bl = 0;
      for (int k = 0; k < 128; k++) if (mx[k]) bl = k + 1;
      up   = (bl <= 63) ? 63 - bl : 0;
      down = (bl > 63) ? bl - 63 : 0;
      sh   = 2 * FRAC_BITS + 1 - 16 + up - down;
      sq = '0;
      for (int i = 0; i < 3; i++) begin
        a[i] = (up != 0) ? 64'(mag[i] << up) : 64'(mag[i] >> down);
        sq = sq + {64'd0, a[i]} * {64'd0, a[i]};
      end
      lroot = isqrt128(sq);
      for (int i = 0; i < 3; i++) begin
        num = {64'd0, a[i]} << 31;
        q = 64'(num / {64'd0, lroot});
        q = (q + 64'd1) >> 1;
        if (q > 64'(NORM_ONE)) q = 64'(NORM_ONE);
        nq[i] = (neg[i] != t.flip) ? -32'(q) : 32'(q);
      end
      if (sh > 64) area = '0;
      else if (sh > 0) area = ((lroot >> (sh - 1)) + 64'd1) >> 1;
      else if (lroot > (64'(AREA_MAX) >> (-sh))) area = 64'(AREA_MAX);
      else area = lroot << (-sh);
      if (area > 64'(AREA_MAX)) area = 64'(AREA_MAX);
    end
    res = '0;
    res[31:0]    = cen[0][31:0];
    res[63:32]   = cen[1][31:0];
    res[95:64]   = cen[2][31:0];
    res[128:96]  = rad[32:0];
    res[160:129] = nq[0];
    res[192:161] = nq[1];
    res[224:193] = nq[2];
    res[272:225] = area[47:0];
    return res;
  endfunction

  task automatic check_geometry(logic [OUT_W-1:0] got);
    logic [OUT_W-1:0] want;
    int               lo[8] = '{0, 32, 64, 96, 129, 161, 193, 225};
    int               wd[8] = '{32, 32, 32, 33, 32, 32, 32, 48};
    string            nm[8] = '{"centroid_x", "centroid_y", "centroid_z", "bound_radius",
                                "normal_x", "normal_y", "normal_z", "area"};
    logic [63:0]      e, g, msk;
    if (geom_expected_q.size() == 0) begin
      $display("%0t: unexpected result beat %h", $time, got);
      errors++;
      return;
    end
    want = geom_expected_q.pop_front();
    for (int f = 0; f < 8; f++) begin
      msk = (64'd1 << wd[f]) - 1;
      e = 64'(want >> lo[f]) & msk;
      g = 64'(got >> lo[f]) & msk;
      if (e !== g) begin
        $display("%0t: %s expected %h actual %h", $time, nm[f], e, g);
        errors++;
      end
    end
  endtask

  // result side: check, then choose next ready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_geometry(m_axis_tdata);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_cnt  = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WD_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_triangle(triangle_t t);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= t.crd;
    s_axis_tuser  <= t.flip;
    do @(posedge clk_i); while (!s_axis_tready);
    geom_expected_q.push_back(predict_geometry(t));
  endtask

  function automatic logic [31:0] pick_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< $urandom_range(16);
      default: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0;
        endcase
      end
    endcase
  endfunction

  function automatic triangle_t random_triangle();
    triangle_t t;
    int        mode;
    mode = $urandom_range(2);
    for (int k = 0; k < 9; k++) t.crd[k] = pick_coord($urandom_range(5) == 0 ? 2 : mode);
    // collapse the triangle now and then: repeated or collinear vertex
    case ($urandom_range(9))
      0: for (int j = 0; j < 3; j++) t.crd[6+j] = t.crd[j];
      1: for (int j = 0; j < 3; j++) t.crd[6+j] = 2 * t.crd[3+j] - t.crd[j];
      default: ;
    endcase
    t.flip = 1'($urandom_range(1));
    return t;
  endfunction

  function automatic triangle_t make_tri(logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
                                         logic [31:0] c3, logic [31:0] c4, logic [31:0] c5,
                                         logic [31:0] c6, logic [31:0] c7, logic [31:0] c8,
                                         logic f);
    triangle_t t;
    t.crd = {c8, c7, c6, c5, c4, c3, c2, c1, c0};
    t.flip = f;
    return t;
  endfunction

  task automatic test_directed();
    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] MN = 32'h8000_0000;
    localparam logic [31:0] MX = 32'h7FFF_FFFF;
    idle_pct = 0;
    stall_pct = 0;
    send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    send_triangle(make_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 1'b0));
    send_triangle(make_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 1'b1));
    send_triangle(make_tri(0, 0, 0, 0, ONE, 0, 0, 0, ONE, 1'b0));
    send_triangle(make_tri(0, 0, 0, 0, 0, ONE, ONE, 0, 0, 1'b1));
    send_triangle(make_tri(0, 0, 0, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE, 1'b1));
    send_triangle(make_tri(MX, MX, MX, MX, MX, MX, MX, MX, MX, 1'b0));
    send_triangle(make_tri(MN, MN, MN, MN, MN, MN, MN, MN, MN, 1'b1));
    send_triangle(make_tri(MN, MN, MN, MX, MN, MN, MN, MX, MN, 1'b0));
    send_triangle(make_tri(MN, MN, MN, MX, MN, MN, MN, MX, MN, 1'b1));
    send_triangle(make_tri(MX, MN, 0, MN, MX, MN, 0, MN, MX, 1'b0));
    send_triangle(make_tri(MN, MX, MN, MX, MN, MX, MN, MN, MX, 1'b1));
    send_triangle(make_tri(MN, MN, MN, MX, MX, MX, MN, MX, MN, 1'b0));
    send_triangle(make_tri(1, 2, 3, 4, 5, 6, 7, 8, 10, 1'b0));
    send_triangle(make_tri(-1, -1, -1, 0, 0, 0, 1, 0, 0, 1'b1));
    send_triangle(make_tri(1, 0, 0, 0, 1, 0, 0, 0, 1, 1'b0));
    send_triangle(make_tri(2, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_triangle(make_tri(MX, 0, 0, MX, 1, 0, MX, 0, 1, 1'b1));
    send_triangle(make_tri(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 1, 1, 1, 1, 1'b0));
  endtask

  task automatic test_random_phase(int n, int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
    repeat (n) send_triangle(random_triangle());
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_seq++;
    repeat (200) send_triangle(random_triangle());
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_phase(250, 0, 0);
    test_random_phase(220, 45, 0);
    test_random_phase(220, 0, 45);
    test_random_phase(220, 25, 25);
    test_backpressure();
    s_axis_tvalid <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    while (geom_expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
